>>> src/mtr_pkg.sv
// package for the matrix transpose / rotate block
// holds sizes, register indexes, controller-datapath structs and the dimension clamp
// no dependencies
package mtr_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 16;

  // fixed field widths
  localparam int ELEM_W  = 16;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
  localparam int STORE_W = (DATA_WIDTH < ELEM_W) ? DATA_WIDTH : ELEM_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd2;

  localparam logic MODE_TRANSPOSE = 1'b0;
  localparam logic MODE_ROTATE    = 1'b1;

  typedef struct packed {
    logic load_wr;   // write accepted element and step load position
    logic rd_en;     // read store at current result position
    logic emit_adv;  // result taken, step result position
  } mtr_cmd_t;

  typedef struct packed {
    logic load_done; // load position is the final element
    logic emit_done; // result position is the final result
  } mtr_stat_t;

  // highest index for a configured dimension, zero read as one, oversize as MAX_DIM
  function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > CFG_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM - 1);
    end else begin
      res = DIM_W'(v - CFG_W'(1));
    end
    return res;
  endfunction

endpackage

>>> src/mtr_if.sv
// valid/ready channel interfaces for the matrix transpose / rotate block
// depends on mtr_pkg
interface mtr_in_if import mtr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface mtr_out_if import mtr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] out_element;
  logic [IDX_W-1:0]  out_row;
  logic [IDX_W-1:0]  out_col;
  logic              last;

  modport source (output valid, output out_element, output out_row, output out_col,
                  output last, input ready);
  modport sink   (input valid, input out_element, input out_row, input out_col,
                  input last, output ready);
endinterface

>>> src/mtr_ctrl.sv
// controller for the matrix transpose / rotate block: load, read and show phases
// depends on mtr_pkg
module mtr_ctrl import mtr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mtr_stat_t stat_i,
  output mtr_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_SHOW
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_SHOW);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_wr  = in_ready_o && in_valid_i;
    cmd_o.rd_en    = (state_q == ST_READ);
    cmd_o.emit_adv = out_valid_o && out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (cmd_o.load_wr && stat_i.load_done) state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_SHOW;
        end
        ST_SHOW: begin
          if (cmd_o.emit_adv) state_q <= stat_i.emit_done ? ST_LOAD : ST_READ;
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is shown");

  a_load_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_wr && stat_i.load_done |=> !in_ready_o && !out_valid_o)
    else $error("final element did not start the result run");

  a_read_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> out_valid_o)
    else $error("store read not followed by a result");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_adv && stat_i.emit_done |=> in_ready_o)
    else $error("final result did not return to loading");

endmodule

>>> src/mtr_datapath.sv
// datapath for the matrix transpose / rotate block: config registers,
// position counters, element store and result register; depends on mtr_pkg
module mtr_datapath import mtr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [ELEM_W-1:0]    element_i,
  input  mtr_cmd_t             cmd_i,
  output mtr_stat_t            stat_o,
  output logic [ELEM_W-1:0]    out_element_o,
  output logic [IDX_W-1:0]     out_row_o,
  output logic [IDX_W-1:0]     out_col_o,
  output logic                 out_last_o
);

  logic [CFG_W-1:0] row_count_q;
  logic [CFG_W-1:0] col_count_q;
  logic             mode_q;

  logic [DIM_W-1:0] rows_last, cols_last;

  // load position (input row, column) and result position (result row, column)
  logic [DIM_W-1:0] ld_r_q, ld_c_q;
  logic [DIM_W-1:0] em_i_q, em_j_q;

  logic [DIM_W-1:0]  src_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  logic [STORE_W-1:0] store_q [MAX_DIM*MAX_DIM];
  logic [STORE_W-1:0] rd_data_q;

  logic load_done, emit_done;

  assign rows_last = dim_last(row_count_q);
  assign cols_last = dim_last(col_count_q);

  assign load_done = (ld_r_q == rows_last) && (ld_c_q == cols_last);
  assign emit_done = (em_i_q == cols_last) && (em_j_q == rows_last);

  always_comb begin
    stat_o           = '0;
    stat_o.load_done = load_done;
    stat_o.emit_done = emit_done;
  end

  // rotation reverses each result row
  assign src_r   = (mode_q == MODE_ROTATE) ? (rows_last - em_j_q) : em_j_q;
  assign wr_addr = ADDR_W'(ld_r_q) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_c_q);
  assign rd_addr = ADDR_W'(src_r) * ADDR_W'(MAX_DIM) + ADDR_W'(em_i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CFG_W'(MAX_DIM);
      col_count_q <= CFG_W'(MAX_DIM);
      mode_q      <= MODE_TRANSPOSE;
      ld_r_q      <= '0;
      ld_c_q      <= '0;
      em_i_q      <= '0;
      em_j_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ROW_COUNT: begin
            row_count_q <= cfg_data_i;
            ld_r_q      <= '0;
            ld_c_q      <= '0;
          end
          REG_COL_COUNT: begin
            col_count_q <= cfg_data_i;
            ld_r_q      <= '0;
            ld_c_q      <= '0;
          end
          REG_MODE: begin
            mode_q <= cfg_data_i[0];
          end
          default: begin
          end
        endcase
      end else if (cmd_i.load_wr) begin
        if (load_done) begin
          ld_r_q <= '0;
          ld_c_q <= '0;
          em_i_q <= '0;
          em_j_q <= '0;
        end else if (ld_c_q == cols_last) begin
          ld_c_q <= '0;
          ld_r_q <= ld_r_q + DIM_W'(1);
        end else begin
          ld_c_q <= ld_c_q + DIM_W'(1);
        end
      end else if (cmd_i.emit_adv) begin
        if (em_j_q == rows_last) begin
          em_j_q <= '0;
          em_i_q <= emit_done ? '0 : em_i_q + DIM_W'(1);
        end else begin
          em_j_q <= em_j_q + DIM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      store_q[wr_addr] <= element_i[STORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= store_q[rd_addr];
    end
  end

  assign out_element_o = ELEM_W'(rd_data_q);
  assign out_row_o     = IDX_W'(em_i_q);
  assign out_col_o     = IDX_W'(em_j_q);
  assign out_last_o    = emit_done;

endmodule

>>> src/matrix_transpose_rotate.sv
// Loads a matrix of row_count x col_count elements, one item per cycle in row-major
// order, then emits its transpose (mode 0) or clockwise rotation (mode 1) as
// col_count x row_count results in row-major order, each with its position and a
// last flag. Each result passes through a registered read of the element store
// and is then shown until it is taken; the next result is read only after
// that. No input is taken while a result run is in progress. Writing row_count or
// col_count restarts the load; a mode write takes effect from the next store read.
// top level: depends on mtr_pkg, mtr_if, mtr_ctrl and mtr_datapath
module matrix_transpose_rotate import mtr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  mtr_in_if.sink               in_i,
  mtr_out_if.source            out_o
);

  mtr_cmd_t  cmd;
  mtr_stat_t stat;

  mtr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mtr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .element_i     (in_i.element),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_element_o (out_o.out_element),
    .out_row_o     (out_o.out_row),
    .out_col_o     (out_o.out_col),
    .out_last_o    (out_o.last)
  );

endmodule
